/* design/mrgb_pkg.sv */
// Shared types, codes, constants and helper functions of the masked RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package mrgb_pkg;

    // Sizes of the pixel path, the ramps and the configuration port.
    localparam int PIXEL_W      = 32;
    localparam int BYTE_W       = 8;
    localparam int TOP_W        = 5;
    localparam int RAMP_ENTRIES = 256;
    localparam int RAMP_AW      = 8;
    localparam int RAMP_VALUE_W = 16;
    localparam int CHAN_W       = 2;
    localparam int CHANNELS     = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    // Register values after reset: a 5-6-5 layout, 16-bit pixels, no gamma.
    localparam logic [PIXEL_W-1:0] RED_MASK_RESET   = 32'h0000_F800;
    localparam logic [PIXEL_W-1:0] GREEN_MASK_RESET = 32'h0000_07E0;
    localparam logic [PIXEL_W-1:0] BLUE_MASK_RESET  = 32'h0000_001F;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED_MASK     = 3'd0,
        CFG_GREEN_MASK   = 3'd1,
        CFG_BLUE_MASK    = 3'd2,
        CFG_PIXEL_SIZE   = 3'd3,
        CFG_GAMMA_ENABLE = 3'd4
    } cfg_index_t;

    // Source pixel widths.
    typedef enum logic [1:0] {
        PIX_16      = 2'd0,
        PIX_24      = 2'd1,
        PIX_32      = 2'd2,
        PIX_UNKNOWN = 2'd3
    } pix_size_t;

    // Input commands.
    typedef enum logic {
        CMD_CONVERT    = 1'b0,
        CMD_RAMP_WRITE = 1'b1
    } cmd_t;

    // Ramp selection codes; these also serve as the channel index of the ramp arrays.
    typedef enum logic [CHAN_W-1:0] {
        RAMP_RED   = 2'd0,
        RAMP_GREEN = 2'd1,
        RAMP_BLUE  = 2'd2,
        RAMP_NONE  = 2'd3
    } ramp_chan_t;

    // One input item as held in the input stage.
    typedef struct packed {
        logic                    command;
        logic [PIXEL_W-1:0]      pixel;
        logic [CHAN_W-1:0]       ramp_channel;
        logic [RAMP_AW-1:0]      ramp_index;
        logic [RAMP_VALUE_W-1:0] ramp_value;
    } in_item_t;

    // Position of the highest set bit of a mask; zero for an empty mask.
    function automatic logic [TOP_W-1:0] top_bit(input logic [PIXEL_W-1:0] mask);
        logic [TOP_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < PIXEL_W; i++) begin
            if (mask[i]) begin
                pos = TOP_W'(i);
            end
        end
        return pos;
    endfunction

    // Scales a masked field so that its top bit lands on bit 7, then keeps eight bits.
    // This covers both the narrow case (field moved up) and the wide case
    // (only the top eight bits of the field survive).
    function automatic logic [BYTE_W-1:0] channel_byte(
        input logic [PIXEL_W-1:0] px,
        input logic [PIXEL_W-1:0] mask,
        input logic [TOP_W-1:0]   top
    );
        logic [PIXEL_W-1:0] masked;
        logic [PIXEL_W-1:0] shifted;
        masked = px & mask;
        if (top >= TOP_W'(BYTE_W - 1)) begin
            shifted = masked >> (top - TOP_W'(BYTE_W - 1));
        end
        else begin
            shifted = masked << (TOP_W'(BYTE_W - 1) - top);
        end
        return shifted[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/mrgb_in_if.sv */
// Input channel: pixel conversion and gamma ramp write commands.
`timescale 1ns / 1ps
`default_nettype none

interface mrgb_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [mrgb_pkg::PIXEL_W-1:0]        pixel;
    logic [mrgb_pkg::CHAN_W-1:0]         ramp_channel;
    logic [mrgb_pkg::RAMP_AW-1:0]        ramp_index;
    logic [mrgb_pkg::RAMP_VALUE_W-1:0]   ramp_value;

    modport source (
        output valid, command, pixel, ramp_channel, ramp_index, ramp_value,
        input  ready
    );

    modport sink (
        input  valid, command, pixel, ramp_channel, ramp_index, ramp_value,
        output ready
    );
endinterface

`default_nettype wire

/* design/mrgb_out_if.sv */
// Output channel: converted 8-bit blue, green and red.
`timescale 1ns / 1ps
`default_nettype none

interface mrgb_out_if;
    logic                        valid;
    logic                        ready;
    logic [mrgb_pkg::BYTE_W-1:0] blue;
    logic [mrgb_pkg::BYTE_W-1:0] green;
    logic [mrgb_pkg::BYTE_W-1:0] red;

    modport source (
        output valid, blue, green, red,
        input  ready
    );

    modport sink (
        input  valid, blue, green, red,
        output ready
    );
endinterface

`default_nettype wire

/* design/mrgb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mrgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/masked_rgb_to_rgb888_gamma.sv */
// Top level of the masked RGB to RGB888 converter with per-channel gamma ramps.
//
// Channels: pix (sink) takes commands. A convert command carries a raw pixel whose
// fields are described by the red, green and blue mask registers; a ramp write
// command stores one 16-bit entry in the red, green or blue gamma ramp and gives
// no result. rgb (source) gives one 8-bit blue, green, red result per convert.
// Configuration is written through cfg_we, cfg_index and cfg_data only while idle;
// this binds the user, as the block itself does not enforce it. A convert transfer
// at the input passes the input register, the ramp read register and the result
// register before its result is valid on rgb.
// Throughput: one command per cycle while pix.ready is high; each stage passes its
// item on whenever the stage after it is free, so the block keeps taking items
// while a result waits. A stalled receiver holds the result steady; items behind
// it fill the free stages and, once the clearing pass is over, pix.ready falls
// only when all three stages are full. Reset: masks return to a 5-6-5 layout,
// 16-bit pixels, gamma off. pix.ready stays low after reset while a clearing pass
// writes the identity value into one entry of all three ramps per cycle, 256 in all.
`timescale 1ns / 1ps
`default_nettype none

module masked_rgb_to_rgb888_gamma (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mrgb_in_if.sink                                  pix,
    mrgb_out_if.source                               rgb,
    input  wire logic                                cfg_we,
    input  wire logic [mrgb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mrgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers; the top bit of each mask is kept beside it.
    logic [mrgb_pkg::PIXEL_W-1:0] mask_reg [mrgb_pkg::CHANNELS];
    logic [mrgb_pkg::TOP_W-1:0]   top_reg  [mrgb_pkg::CHANNELS];
    logic [1:0]                   size_reg;
    logic                         gamma_reg;

    // Pipeline stages.
    logic                         s1_valid_reg;
    mrgb_pkg::in_item_t           s1_item_reg;
    logic                         s2_valid_reg;
    logic [mrgb_pkg::BYTE_W-1:0]  s2_byte_reg [mrgb_pkg::CHANNELS];
    logic                         s3_valid_reg;
    logic [mrgb_pkg::BYTE_W-1:0]  s3_byte_reg [mrgb_pkg::CHANNELS];

    // Clearing pass that loads the identity ramp after reset.
    logic                         clr_busy_reg;
    logic [mrgb_pkg::RAMP_AW-1:0] clr_addr_reg;

    logic                         in_ready;
    logic                         s1_ready;
    logic                         s2_ready;
    logic                         s3_ready;
    logic                         s1_convert;
    logic                         s1_ramp_write;
    logic [mrgb_pkg::PIXEL_W-1:0] px_sized;
    logic [mrgb_pkg::BYTE_W-1:0]  s1_byte [mrgb_pkg::CHANNELS];
    logic [mrgb_pkg::BYTE_W-1:0]  ramp_rdata [mrgb_pkg::CHANNELS];
    logic [mrgb_pkg::BYTE_W-1:0]  s3_byte_next [mrgb_pkg::CHANNELS];
    logic [mrgb_pkg::CHANNELS-1:0] ramp_we;
    logic [mrgb_pkg::RAMP_AW-1:0] ram_waddr;
    logic [mrgb_pkg::BYTE_W-1:0]  ram_wdata;

    // Ready chain: a stage loads when it is empty or its item moves on.
    assign s3_ready  = !s3_valid_reg || rgb.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready && !clr_busy_reg;
    assign pix.ready = in_ready;

    assign s1_convert    = s1_valid_reg && (s1_item_reg.command == mrgb_pkg::CMD_CONVERT);
    assign s1_ramp_write = s1_valid_reg && (s1_item_reg.command == mrgb_pkg::CMD_RAMP_WRITE);

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[mrgb_pkg::RAMP_RED]   <= mrgb_pkg::RED_MASK_RESET;
            mask_reg[mrgb_pkg::RAMP_GREEN] <= mrgb_pkg::GREEN_MASK_RESET;
            mask_reg[mrgb_pkg::RAMP_BLUE]  <= mrgb_pkg::BLUE_MASK_RESET;
            top_reg[mrgb_pkg::RAMP_RED]    <= mrgb_pkg::top_bit(mrgb_pkg::RED_MASK_RESET);
            top_reg[mrgb_pkg::RAMP_GREEN]  <= mrgb_pkg::top_bit(mrgb_pkg::GREEN_MASK_RESET);
            top_reg[mrgb_pkg::RAMP_BLUE]   <= mrgb_pkg::top_bit(mrgb_pkg::BLUE_MASK_RESET);
            size_reg                       <= mrgb_pkg::PIX_16;
            gamma_reg                      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrgb_pkg::CFG_RED_MASK:
                begin
                    mask_reg[mrgb_pkg::RAMP_RED] <= cfg_data;
                    top_reg[mrgb_pkg::RAMP_RED]  <= mrgb_pkg::top_bit(cfg_data);
                end
                mrgb_pkg::CFG_GREEN_MASK:
                begin
                    mask_reg[mrgb_pkg::RAMP_GREEN] <= cfg_data;
                    top_reg[mrgb_pkg::RAMP_GREEN]  <= mrgb_pkg::top_bit(cfg_data);
                end
                mrgb_pkg::CFG_BLUE_MASK:
                begin
                    mask_reg[mrgb_pkg::RAMP_BLUE] <= cfg_data;
                    top_reg[mrgb_pkg::RAMP_BLUE]  <= mrgb_pkg::top_bit(cfg_data);
                end
                mrgb_pkg::CFG_PIXEL_SIZE:
                begin
                    size_reg <= cfg_data[1:0];
                end
                mrgb_pkg::CFG_GAMMA_ENABLE:
                begin
                    gamma_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clearing pass: one entry of every ramp per cycle, from index 0 up to the last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == mrgb_pkg::RAMP_AW'(mrgb_pkg::RAMP_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Input stage: holds the accepted command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pix.valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && pix.valid)
        begin
            s1_item_reg.command      <= pix.command;
            s1_item_reg.pixel        <= pix.pixel;
            s1_item_reg.ramp_channel <= pix.ramp_channel;
            s1_item_reg.ramp_index   <= pix.ramp_index;
            s1_item_reg.ramp_value   <= pix.ramp_value;
        end
    end

    // Trim the pixel to its source width; an unknown width gives a zero pixel.
    always_comb
    begin
        case (size_reg)
            mrgb_pkg::PIX_16:  px_sized = {16'd0, s1_item_reg.pixel[15:0]};
            mrgb_pkg::PIX_24:  px_sized = {8'd0, s1_item_reg.pixel[23:0]};
            mrgb_pkg::PIX_32:  px_sized = s1_item_reg.pixel;
            default:           px_sized = '0;
        endcase
    end

    // Ramp write port: the clearing pass stores index i, the high byte of i * 257.
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_item_reg.ramp_index;
    assign ram_wdata = clr_busy_reg ? clr_addr_reg
                     : s1_item_reg.ramp_value[mrgb_pkg::RAMP_VALUE_W-1:mrgb_pkg::BYTE_W];

    // Per-channel extraction, ramp storage and ramp lookup.
    for (genvar c = 0; c < mrgb_pkg::CHANNELS; c++)
    begin : g_chan
        assign s1_byte[c] = mrgb_pkg::channel_byte(px_sized, mask_reg[c], top_reg[c]);
        assign ramp_we[c] = s1_ramp_write && s2_ready
                            && (s1_item_reg.ramp_channel == mrgb_pkg::CHAN_W'(c));

        // Only the high byte of a ramp entry is ever used, so only it is stored.
        mrgb_ram #(
            .WIDTH (mrgb_pkg::BYTE_W),
            .DEPTH (mrgb_pkg::RAMP_ENTRIES)
        ) u_ramp (
            .clk   (clk),
            .we    (clr_busy_reg || ramp_we[c]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (s1_convert && s2_ready),
            .raddr (s1_byte[c]),
            .rdata (ramp_rdata[c])
        );

        // Ramp stage: keep the byte beside the RAM read.
        always_ff @(posedge clk)
        begin
            if (s1_convert && s2_ready)
            begin
                s2_byte_reg[c] <= s1_byte[c];
            end
        end

        assign s3_byte_next[c] = gamma_reg ? ramp_rdata[c] : s2_byte_reg[c];

        // Result register.
        always_ff @(posedge clk)
        begin
            if (s3_ready && s2_valid_reg)
            begin
                s3_byte_reg[c] <= s3_byte_next[c];
            end
        end
    end

    // Ramp stage control: a ramp write leaves the pipeline here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_convert;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign rgb.valid = s3_valid_reg;
    assign rgb.red   = s3_byte_reg[mrgb_pkg::RAMP_RED];
    assign rgb.green = s3_byte_reg[mrgb_pkg::RAMP_GREEN];
    assign rgb.blue  = s3_byte_reg[mrgb_pkg::RAMP_BLUE];

endmodule

`default_nettype wire

/* design/mrgb_checker.sv */
// Port-level checks of the converter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module mrgb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [mrgb_pkg::BYTE_W-1:0] blue,
    input wire logic [mrgb_pkg::BYTE_W-1:0] green,
    input wire logic [mrgb_pkg::BYTE_W-1:0] red
);

    logic in_xfer;
    logic ready_seen_reg;

    assign in_xfer = in_valid && in_ready;

    // Marks the end of the ramp loading that follows reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_seen_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ready_seen_reg <= 1'b1;
        end
    end

    // Once the ramps are loaded, the input can only stall when the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ready_seen_reg && (!out_valid || out_ready)) |-> in_ready)
    else $error("input stalled while the output was free");

    // No result appears without a command transferred recently enough to reach the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !in_xfer && !$past(in_xfer) && !$past(in_xfer, 2)) |=> !out_valid)
    else $error("result appeared without a recent input transfer");

    // A result that is not taken stays and holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(blue) && $stable(green) && $stable(red)))
    else $error("stalled result changed or was dropped");

endmodule

bind masked_rgb_to_rgb888_gamma mrgb_checker u_mrgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .blue      (rgb.blue),
    .green     (rgb.green),
    .red       (rgb.red)
);

`default_nettype wire
